### hdl/lwe_encrypt_matvec_mod_top_defines.svh
// ----------------------------------------------------------------------------
// lwe encryption engine assertion macros
// concurrent assertion helpers, empty bodies in synthesis
// ----------------------------------------------------------------------------
`ifndef LWE_ENCRYPT_MATVEC_MOD_TOP_DEFINES_SVH
`define LWE_ENCRYPT_MATVEC_MOD_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define LWE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LWE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LWE_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define LWE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

### hdl/lwe_enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwe_enc_pkg
// shared constants and codes of the lwe encryption engine
// ----------------------------------------------------------------------------
package lwe_enc_pkg;

    // parameter defaults
    localparam int DEF_MAX_ROWS  = 32;
    localparam int DEF_MAX_COLS  = 512;
    localparam int DEF_ELEM_BITS = 20;

    // configuration registers
    localparam int MOD_W  = 21;
    localparam int ROWS_W = 6;
    localparam int COLS_W = 10;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_ADDR_W-1:0] CFG_MODULUS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLS    = 2'd2;

    localparam logic [MOD_W-1:0]  MODULUS_RST = 21'd1000000;
    localparam logic [ROWS_W-1:0] ROWS_RST    = 6'd30;
    localparam logic [COLS_W-1:0] COLS_RST    = 10'd270;

    localparam logic [MOD_W-1:0] MOD_MIN = 21'd2;
    localparam logic [MOD_W-1:0] MOD_MAX = 21'd1048576;

    // request kinds
    localparam int REQ_W = 3;
    localparam logic [REQ_W-1:0] REQ_WR_MATRIX = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WR_PUBVEC = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WR_SECRET = 3'd2;
    localparam logic [REQ_W-1:0] REQ_COLUMN    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PAYLOAD   = 3'd4;

    // result kinds
    localparam logic KIND_COLUMN  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // field widths
    localparam int ROW_W    = 5;
    localparam int COL_W    = 9;
    localparam int VALUE_W  = 20;
    localparam int NOISE_W  = 4;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;

    // remainder width: holds 2*rem+1 for any modulus up to MOD_MAX
    localparam int REM_W = 22;
    // width of the initial term 8*q + noise
    localparam int INIT_W = 25;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAC  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage

### hdl/lwe_encrypt_matvec_mod_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwe_encrypt_matvec_mod_top
// dual lwe encryption engine: matrix column and payload inner products mod q
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one request per transaction, kind in s_tuser. writes to the
//   matrix, public vector or secret store finish in the accept cycle. column
//   and payload requests read the stores row by row, one multiply per row,
//   and the sum is reduced mod q by a two-bit-per-cycle restoring remainder.
//   m_ channel: one result per column or payload request; kind in m_tuser.
//   a column request at or past cols_in_use and an unknown kind give nothing.
//   one request is worked on at a time; the next one is taken once the
//   engine is back in idle. s_tready is high whenever the engine is idle,
//   also while a finished result waits on m_tready.
//   a stalled result holds in the output register; a following request
//   that finishes waits in its last state until the register is free.
//   reset clears control and config registers; the stores are not cleared
//   and must be written before they are read. configure only when idle.
// ----------------------------------------------------------------------------
`include "lwe_encrypt_matvec_mod_top_defines.svh"

module lwe_encrypt_matvec_mod_top
    import lwe_enc_pkg::*;
#(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int ELEM_BITS = DEF_ELEM_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // row_index[4:0], col_index[13:5], elem_value[33:14], noise[37:34],
    // plain_bit[38], zero pad[39]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // req_type[2:0]
    input  logic [REQ_W-1:0]      s_tuser,
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_value[19:0], result_col[28:20], zero pad[31:29]
    output logic [M_DATA_W-1:0]   m_tdata,
    // result_kind[0]
    output logic                  m_tuser
);

    localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W   = $clog2(MAX_ROWS + 1);
    localparam int MEM_D   = MAX_ROWS * MAX_COLS;
    localparam int MEM_AW  = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam int VEC_D   = 2 ** (RW + 1);
    localparam int PROD_W  = 2 * ELEM_BITS;
    localparam int SUM_W   = PROD_W + $clog2(MAX_ROWS);
    localparam int ACC_RAW = ((SUM_W > INIT_W) ? SUM_W : INIT_W) + 1;
    localparam int ACC_W   = ACC_RAW + (ACC_RAW % 2);
    localparam int DIV_STEPS = ACC_W / 2;
    localparam int DC_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // request fields
    logic [ROW_W-1:0]   s_row;
    logic [COL_W-1:0]   s_col;
    logic [VALUE_W-1:0] s_elem;
    logic [NOISE_W-1:0] s_noise;
    logic               s_bit;

    assign s_row   = s_tdata[4:0];
    assign s_col   = s_tdata[13:5];
    assign s_elem  = s_tdata[33:14];
    assign s_noise = s_tdata[37:34];
    assign s_bit   = s_tdata[38];

    // configuration registers
    logic [MOD_W-1:0]  modulus_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [COLS_W-1:0] cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RST;
            rows_reg    <= ROWS_RST;
            cols_reg    <= COLS_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MODULUS: modulus_reg <= cfg_wdata[MOD_W-1:0];
                CFG_ROWS:    rows_reg    <= cfg_wdata[ROWS_W-1:0];
                CFG_COLS:    cols_reg    <= cfg_wdata[COLS_W-1:0];
                default:     ;
            endcase
        end
    end

    logic [MOD_W-1:0] q_eff;
    logic [CNT_W-1:0] n_eff;

    assign q_eff = (modulus_reg < MOD_MIN) ? MOD_MIN :
                   (modulus_reg > MOD_MAX) ? MOD_MAX : modulus_reg;
    assign n_eff = (32'(rows_reg) > 32'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(rows_reg);

    // control state
    state_t state_reg, state_next;

    logic                 kind_reg;
    logic [COL_W-1:0]     col_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     rd_row_reg;
    logic                 v1_reg, v2_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [DC_W-1:0]      div_cnt_reg;
    logic                 m_tvalid_reg;
    logic [VALUE_W-1:0]   m_value_reg;
    logic [COL_W-1:0]     m_col_reg;
    logic                 m_kind_reg;

    logic accept, row_ok, col_ok, col_req_ok, start_col, start_pay, start;
    logic issue, mac_done, div_last, out_free;

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign row_ok     = 32'(s_row) < 32'(MAX_ROWS);
    assign col_ok     = 32'(s_col) < 32'(MAX_COLS);
    assign col_req_ok = col_ok && (COLS_W'(s_col) < cols_reg);
    assign start_col  = accept && (s_tuser == REQ_COLUMN) && col_req_ok;
    assign start_pay  = accept && (s_tuser == REQ_PAYLOAD);
    assign start      = start_col || start_pay;
    assign issue      = (state_reg == S_MAC) && (rd_row_reg < n_reg);
    assign mac_done   = (state_reg == S_MAC) && !issue && !v1_reg && !v2_reg;
    assign div_last   = (state_reg == S_DIV) && (div_cnt_reg == DC_W'(DIV_STEPS - 1));
    assign out_free   = !m_tvalid_reg || m_tready;

    // memories
    logic [ELEM_BITS-1:0] mat_mem [MEM_D];
    logic [ELEM_BITS-1:0] vec_mem [VEC_D];
    logic [ELEM_BITS-1:0] mat_q, sec_q, pub_q;

    logic [MEM_AW-1:0] mat_wr_addr, mat_rd_addr;
    logic [RW:0]       vec_wr_addr, sec_rd_addr, pub_rd_addr;
    logic [ELEM_BITS-1:0] elem_w;

    assign elem_w      = ELEM_BITS'(s_elem);
    assign mat_wr_addr = MEM_AW'(MEM_AW'(s_row) * MEM_AW'(MAX_COLS)) + MEM_AW'(s_col);
    assign mat_rd_addr = MEM_AW'(MEM_AW'(rd_row_reg[RW-1:0]) * MEM_AW'(MAX_COLS))
                         + MEM_AW'(col_reg);
    // upper address bit selects secret (1) or public vector (0)
    assign vec_wr_addr = {(s_tuser == REQ_WR_SECRET), RW'(s_row)};
    assign sec_rd_addr = {1'b1, rd_row_reg[RW-1:0]};
    assign pub_rd_addr = {1'b0, rd_row_reg[RW-1:0]};

    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == REQ_WR_MATRIX) && row_ok && col_ok) begin
            mat_mem[mat_wr_addr] <= elem_w;
        end
        if (issue) begin
            mat_q <= mat_mem[mat_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && ((s_tuser == REQ_WR_PUBVEC) || (s_tuser == REQ_WR_SECRET)) && row_ok) begin
            vec_mem[vec_wr_addr] <= elem_w;
        end
        if (issue) begin
            sec_q <= vec_mem[sec_rd_addr];
            pub_q <= vec_mem[pub_rd_addr];
        end
    end

    // initial accumulator: 8*q + noise for a column, bit*floor(q/2) for payload
    logic [INIT_W-1:0] init_col, init_pay;

    assign init_col = INIT_W'({q_eff, 3'b000}) + {{(INIT_W-NOISE_W){s_noise[NOISE_W-1]}}, s_noise};
    assign init_pay = s_bit ? INIT_W'(q_eff >> 1) : '0;

    // two restoring remainder steps per cycle
    logic [REM_W-1:0] q_ext, rem_t1, rem_t2;

    always_comb begin
        q_ext  = REM_W'(q_eff);
        rem_t1 = {rem_reg[REM_W-2:0], acc_reg[ACC_W-1]};
        if (rem_t1 >= q_ext) begin
            rem_t1 = rem_t1 - q_ext;
        end
        rem_t2 = {rem_t1[REM_W-2:0], acc_reg[ACC_W-2]};
        if (rem_t2 >= q_ext) begin
            rem_t2 = rem_t2 - q_ext;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_MAC;
            S_MAC:  if (mac_done) state_next = S_DIV;
            S_DIV:  if (div_last) state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rd_row_reg   <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (start) begin
                rd_row_reg <= '0;
            end else if (issue) begin
                rd_row_reg <= rd_row_reg + 1'b1;
            end
            if (mac_done) begin
                div_cnt_reg <= '0;
            end else if (state_reg == S_DIV) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if ((state_reg == S_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            kind_reg <= start_pay ? KIND_PAYLOAD : KIND_COLUMN;
            col_reg  <= s_col;
            n_reg    <= n_eff;
            acc_reg  <= ACC_W'(start_pay ? init_pay : init_col);
        end else if (v2_reg) begin
            acc_reg  <= acc_reg + ACC_W'(prod_reg);
        end else if (state_reg == S_DIV) begin
            acc_reg  <= {acc_reg[ACC_W-3:0], 2'b00};
        end
        if (v1_reg) begin
            prod_reg <= PROD_W'((kind_reg == KIND_PAYLOAD) ? pub_q : mat_q) * PROD_W'(sec_q);
        end
        if (mac_done) begin
            rem_reg <= '0;
        end else if (state_reg == S_DIV) begin
            rem_reg <= rem_t2;
        end
        if ((state_reg == S_DONE) && out_free) begin
            m_value_reg <= rem_reg[VALUE_W-1:0];
            m_kind_reg  <= kind_reg;
            m_col_reg   <= (kind_reg == KIND_PAYLOAD) ? '0 : col_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_col_reg, m_value_reg};
    assign m_tuser  = m_kind_reg;

    `LWE_ASSERT_NEXT(a_start_to_mac, aclk, aresetn, start, state_reg == S_MAC, "start did not enter row loop")
    `LWE_ASSERT_SAME(a_row_bound, aclk, aresetn, state_reg == S_MAC, rd_row_reg <= n_reg, "row counter past row count")
    `LWE_ASSERT_SAME(a_rem_bound, aclk, aresetn, state_reg == S_DIV, rem_reg < REM_W'(q_eff), "partial remainder not below modulus")
    `LWE_ASSERT_NEXT(a_result_load, aclk, aresetn, (state_reg == S_DONE) && out_free, m_tvalid && (state_reg == S_IDLE), "finished result not loaded")
    `LWE_ASSERT_SAME(a_payload_col, aclk, aresetn, m_tvalid && (m_tuser == KIND_PAYLOAD), m_tdata[28:20] == '0, "payload result with nonzero column")

endmodule
